// File: rtl/ps2_mouse_packet_tracker_defines.svh
// assertion macros for the ps2 mouse packet tracker
`ifndef PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH
`define PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define PMT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define PMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define PMT_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define PMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/pmt_pkg.sv
package pmt_pkg;

    // coordinate width of the accumulated pointer position
    localparam int COORD_W = 16;

    // configuration port widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_SIZE    = 2'd0,
        CFG_TIMEOUT_TICKS = 2'd1,
        CFG_SETTLE_COUNT  = 2'd2
    } t_cfg_idx;

    // reset values of the configuration registers
    localparam logic [7:0] TIMEOUT_RESET = 8'd5;
    localparam logic [3:0] SETTLE_RESET  = 4'd1;

    // header byte bit positions of the delta signs
    localparam int X_SIGN_BIT = 4;
    localparam int Y_SIGN_BIT = 5;

    // packet lengths
    localparam logic [2:0] PKT_LEN_3 = 3'd3;
    localparam logic [2:0] PKT_LEN_4 = 3'd4;

    // sign extend a 9-bit delta to coordinate width
    function automatic logic [COORD_W-1:0] delta_ext(input logic neg, input logic [7:0] mag);
        logic [8:0] d9;
        d9 = {neg, mag};
        return {{(COORD_W-9){d9[8]}}, d9};
    endfunction

endpackage

// File: rtl/ps2_mouse_packet_tracker.sv
// ps2 mouse packet tracker
//
// input channel: one beat per event, i_byte_received high with a mouse byte in
// i_data_byte, or low for an idle tick. output channel: one beat per event
// with the pointer position, buttons, packet-applied flag and packet length
// as they stand after that event.
// an input beat passes through the input register, then the state update and
// the output register. one event is taken every cycle while o_stall is low;
// the state update is a single short add/compare stage.
// when the receiver stalls, the output register holds its beat and the input
// register still takes one more event, after which o_stall rises.
// the configuration port is a plain write port (i_cfg_we, i_cfg_index,
// i_cfg_data); index 0 loads the packet length, 1 the idle timeout, 2 the
// settle count, 3 is ignored. write it only while the block is empty.
// synchronous active-low reset empties both registers, clears all tracking
// state and loads the default timeout of 5 ticks and settle count of 1.
module ps2_mouse_packet_tracker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_byte_received,
    input  logic [7:0]                   i_data_byte,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [pmt_pkg::COORD_W-1:0] o_pointer_x,
    output logic signed [pmt_pkg::COORD_W-1:0] o_pointer_y,
    output logic [1:0]                   o_buttons,
    output logic                         o_packet_applied,
    output logic [2:0]                   o_packet_bytes,
    input  logic                         i_cfg_we,
    input  logic [pmt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pmt_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pmt_pkg::*;

    `include "ps2_mouse_packet_tracker_defines.svh"

    // pipeline registers
    logic         r_s1_valid;
    logic         r_s1_byte;
    logic [7:0]   r_s1_data;
    logic         r_out_valid;
    logic [COORD_W-1:0] r_out_x;
    logic [COORD_W-1:0] r_out_y;
    logic [1:0]   r_out_buttons;
    logic         r_out_applied;
    logic [2:0]   r_out_bytes;

    // configuration
    logic [7:0]   r_timeout_ticks;
    logic [3:0]   r_settle_count;

    // tracking state
    logic [2:0]   r_byte_index;
    logic [7:0]   r_store [3];
    logic         r_size_is_four;
    logic [7:0]   r_idle_counter;
    logic         r_timeout_spent;
    logic [3:0]   r_settle_left;
    logic [COORD_W-1:0] r_pos_x;
    logic [COORD_W-1:0] r_pos_y;
    logic [1:0]   r_button_bits;

    logic         s1_adv;
    logic         in_take;

    logic [2:0]   n_byte_index;
    logic         n_size_is_four;
    logic [7:0]   n_idle_counter;
    logic         n_timeout_spent;
    logic [3:0]   n_settle_left;
    logic [COORD_W-1:0] n_pos_x;
    logic [COORD_W-1:0] n_pos_y;
    logic [1:0]   n_button_bits;
    logic         n_applied;

    logic [2:0]   idx_inc;
    logic [2:0]   pkt_len;
    logic [7:0]   hdr;
    logic [7:0]   dx;
    logic [7:0]   dy;
    logic         store_we;
    logic [1:0]   store_idx;

    // handshake: output drains when empty or taken, input enters when stage one frees
    assign s1_adv  = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_adv;
    assign in_take = i_valid && !o_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_byte <= i_byte_received;
            r_s1_data <= i_data_byte;
        end
    end

    // event update from the registered beat
    always_comb begin
        pkt_len         = r_size_is_four ? PKT_LEN_4 : PKT_LEN_3;
        idx_inc         = r_byte_index + 3'd1;
        store_we        = 1'b0;
        store_idx       = r_byte_index[1:0];
        hdr             = (r_byte_index == 3'd0) ? r_s1_data : r_store[0];
        dx              = (r_byte_index == 3'd1) ? r_s1_data : r_store[1];
        dy              = (r_byte_index == 3'd2) ? r_s1_data : r_store[2];
        n_byte_index    = r_byte_index;
        n_size_is_four  = r_size_is_four;
        n_idle_counter  = r_idle_counter;
        n_timeout_spent = r_timeout_spent;
        n_settle_left   = r_settle_left;
        n_pos_x         = r_pos_x;
        n_pos_y         = r_pos_y;
        n_button_bits   = r_button_bits;
        n_applied       = 1'b0;

        if (r_s1_byte) begin
            store_we        = (r_byte_index < 3'd3);
            n_byte_index    = idx_inc;
            n_idle_counter  = r_timeout_ticks;
            n_timeout_spent = 1'b0;
            if (idx_inc >= pkt_len) begin
                n_byte_index = 3'd0;
                if (r_settle_left == 4'd0) begin
                    n_button_bits = ~hdr[1:0];
                    n_pos_y       = r_pos_y + delta_ext(hdr[Y_SIGN_BIT], dy);
                    n_pos_x       = r_pos_x - delta_ext(hdr[X_SIGN_BIT], dx);
                    n_applied     = 1'b1;
                end
            end
        end else if (!r_timeout_spent) begin
            if (r_idle_counter == 8'd0) begin
                n_timeout_spent = 1'b1;
                // partial packet at timeout: flip length and start settling
                if (r_byte_index != 3'd0) begin
                    n_settle_left  = r_settle_count;
                    n_size_is_four = ~r_size_is_four;
                end else if (r_settle_left != 4'd0) begin
                    n_settle_left = r_settle_left - 4'd1;
                end
                n_byte_index = 3'd0;
            end else begin
                n_idle_counter = r_idle_counter - 8'd1;
            end
        end
    end

    // tracking state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks <= TIMEOUT_RESET;
            r_settle_count  <= SETTLE_RESET;
            r_byte_index    <= 3'd0;
            r_size_is_four  <= 1'b0;
            r_idle_counter  <= 8'd0;
            r_timeout_spent <= 1'b0;
            r_settle_left   <= 4'd0;
            r_pos_x         <= '0;
            r_pos_y         <= '0;
            r_button_bits   <= 2'd0;
        end else if (s1_adv) begin
            r_byte_index    <= n_byte_index;
            r_size_is_four  <= n_size_is_four;
            r_idle_counter  <= n_idle_counter;
            r_timeout_spent <= n_timeout_spent;
            r_settle_left   <= n_settle_left;
            r_pos_x         <= n_pos_x;
            r_pos_y         <= n_pos_y;
            r_button_bits   <= n_button_bits;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_START_SIZE:    r_size_is_four  <= i_cfg_data[2];
                CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data;
                CFG_SETTLE_COUNT:  r_settle_count  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // packet byte store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store[0] <= 8'd0;
            r_store[1] <= 8'd0;
            r_store[2] <= 8'd0;
        end else if (s1_adv && store_we) begin
            r_store[store_idx] <= r_s1_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_x       <= n_pos_x;
            r_out_y       <= n_pos_y;
            r_out_buttons <= n_button_bits;
            r_out_applied <= n_applied;
            r_out_bytes   <= n_size_is_four ? PKT_LEN_4 : PKT_LEN_3;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_pointer_x      = r_out_x;
    assign o_pointer_y      = r_out_y;
    assign o_buttons        = r_out_buttons;
    assign o_packet_applied = r_out_applied;
    assign o_packet_bytes   = r_out_bytes;

    // checks
    `PMT_ASSERT_NOW(a_idx_range, i_clk, i_rst_n, 1'b1, r_byte_index < 3'd4)
    `PMT_ASSERT_NOW(a_spent_empty, i_clk, i_rst_n, r_timeout_spent, r_byte_index == 3'd0)
    `PMT_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, o_stall, r_out_valid && r_s1_valid)
    `PMT_ASSERT_NEXT(a_flip_settle, i_clk, i_rst_n, s1_adv && !r_s1_byte && !r_timeout_spent && r_idle_counter == 8'd0 && r_byte_index != 3'd0, r_settle_left == $past(r_settle_count) && r_size_is_four != $past(r_size_is_four))

endmodule
